### rtl/core/bmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bracket match checker.
// No dependencies; imported by bmc_cfg, bmc_front, bmc_back and the top level.
package bmc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW      = $clog2(STACK_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam int SYMBOL_W    = 8;
    localparam int STATUS_W    = 3;
    localparam int SCORE_W     = 32;
    localparam int DEPTH_W     = 7;
    localparam int WEIGHT_W    = 16;
    localparam int NUM_WEIGHTS = 4;
    localparam int KIND_W      = 2;

    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [SYMBOL_W-1:0] CH_ROUND_OPEN   = 8'h28;
    localparam logic [SYMBOL_W-1:0] CH_ROUND_CLOSE  = 8'h29;
    localparam logic [SYMBOL_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [SYMBOL_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
    localparam logic [SYMBOL_W-1:0] CH_CURLY_OPEN   = 8'h7B;
    localparam logic [SYMBOL_W-1:0] CH_CURLY_CLOSE  = 8'h7D;
    localparam logic [SYMBOL_W-1:0] CH_ANGLE_OPEN   = 8'h3C;
    localparam logic [SYMBOL_W-1:0] CH_ANGLE_CLOSE  = 8'h3E;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ROUND_RST  = 16'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SQUARE_RST = 16'd57;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CURLY_RST  = 16'd1197;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ANGLE_RST  = 16'd25137;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_ANGLE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_WEIGHT_ROUND  = 2'd0,
        REG_WEIGHT_SQUARE = 2'd1,
        REG_WEIGHT_CURLY  = 2'd2,
        REG_WEIGHT_ANGLE  = 2'd3
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OPENED   = 3'd0,
        ST_MATCHED  = 3'd1,
        ST_CORRUPT  = 3'd2,
        ST_SKIPPED  = 3'd3,
        ST_INVALID  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    // Classified symbol handed from the front end to the stack engine
    typedef struct packed {
        logic  is_bracket;
        logic  is_open;
        t_kind kind;
        logic  line_end;
    } t_item;

    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef t_weight [NUM_WEIGHTS-1:0] t_weights;

endpackage

### rtl/core/bmc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bmc_cfg.sv
`timescale 1ns / 1ps
// APB register file holding the four corruption weights.
// Depends on bmc_pkg.
module bmc_cfg
    import bmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_weights          o_weights
);

    t_weights r_weights;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights[REG_WEIGHT_ROUND]  <= WEIGHT_ROUND_RST;
            r_weights[REG_WEIGHT_SQUARE] <= WEIGHT_SQUARE_RST;
            r_weights[REG_WEIGHT_CURLY]  <= WEIGHT_CURLY_RST;
            r_weights[REG_WEIGHT_ANGLE]  <= WEIGHT_ANGLE_RST;
        end else if (wr_en) begin
            r_weights[idx] <= pwdata[WEIGHT_W-1:0];
        end
    end

    assign prdata    = {{(APB_DW - WEIGHT_W){1'b0}}, r_weights[idx]};
    assign o_weights = r_weights;

endmodule

### rtl/core/bmc_front.sv
`timescale 1ns / 1ps
// Front end: accepts symbols, classifies them and queues them for the stack engine.
// Depends on bmc_pkg.
module bmc_front
    import bmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic                i_line_end,
    output logic                o_q_valid,
    output t_item               o_q_item,
    input  logic                i_q_pop
);

    t_item            r_q [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             push;
    logic             pop;
    t_item            cls;

    always_comb begin
        cls            = '0;
        cls.line_end   = i_line_end;
        cls.is_bracket = 1'b1;
        unique case (i_symbol)
            CH_ROUND_OPEN:   begin cls.is_open = 1'b1; cls.kind = KIND_ROUND;  end
            CH_SQUARE_OPEN:  begin cls.is_open = 1'b1; cls.kind = KIND_SQUARE; end
            CH_CURLY_OPEN:   begin cls.is_open = 1'b1; cls.kind = KIND_CURLY;  end
            CH_ANGLE_OPEN:   begin cls.is_open = 1'b1; cls.kind = KIND_ANGLE;  end
            CH_ROUND_CLOSE:  cls.kind = KIND_ROUND;
            CH_SQUARE_CLOSE: cls.kind = KIND_SQUARE;
            CH_CURLY_CLOSE:  cls.kind = KIND_CURLY;
            CH_ANGLE_CLOSE:  cls.kind = KIND_ANGLE;
            default:         cls.is_bracket = 1'b0;
        endcase
    end

    assign o_ready   = (r_cnt != QCW'(QUEUE_DEPTH));
    assign push      = i_valid & o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop & o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

### rtl/core/bmc_back.sv
`timescale 1ns / 1ps
// Stack engine: applies queued symbols to the bracket stack, scores corrupt lines
// and holds the result register. Depends on bmc_pkg and bmc_ram.
module bmc_back
    import bmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    input  t_weights            i_weights,
    output logic                o_valid,
    input  logic                i_ready,
    output t_status             o_status,
    output logic [SCORE_W-1:0]  o_total_score,
    output logic [SP_W-1:0]     o_stack_depth
);

    // Stack top lives in r_top; entries below it live in the RAM.
    logic [SP_W-1:0]    r_sp, n_sp;
    t_kind              r_top, n_top;
    logic               r_skip, n_skip;
    logic [SCORE_W-1:0] r_score, n_score;
    logic               r_fwd, n_fwd;
    t_kind              r_fwd_data;

    logic               r_out_valid;
    t_status            r_out_status, n_status;
    logic [SCORE_W-1:0] r_out_score;
    logic [SP_W-1:0]    r_out_sp;

    logic               step;
    logic               we;
    logic [STK_AW-1:0]  waddr;
    logic [STK_AW-1:0]  raddr;
    logic [KIND_W-1:0]  rdata;
    t_kind              below;
    logic [SCORE_W:0]   sum;

    assign step    = i_q_valid & (~r_out_valid | i_ready);
    assign o_q_pop = step;
    assign below   = r_fwd ? r_fwd_data : t_kind'(rdata);
    assign sum     = {1'b0, r_score} + {{(SCORE_W + 1 - WEIGHT_W){1'b0}},
                                        i_weights[i_q_item.kind]};

    always_comb begin
        n_sp     = r_sp;
        n_top    = r_top;
        n_skip   = r_skip;
        n_score  = r_score;
        n_status = ST_SKIPPED;
        we       = 1'b0;
        waddr    = STK_AW'(r_sp - 1'b1);
        if (step) begin
            priority if (r_skip) begin
                n_status = ST_SKIPPED;
            end else if (!i_q_item.is_bracket) begin
                n_status = ST_INVALID;
            end else if (i_q_item.is_open) begin
                if (r_sp == SP_W'(STACK_DEPTH)) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    // spill the old top below the new one
                    we       = (r_sp != '0);
                    n_top    = i_q_item.kind;
                    n_sp     = r_sp + 1'b1;
                    n_status = ST_OPENED;
                end
            end else if (r_sp != '0 && r_top == i_q_item.kind) begin
                n_top    = below;
                n_sp     = r_sp - 1'b1;
                n_status = ST_MATCHED;
            end else begin
                n_score  = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
                n_skip   = 1'b1;
                n_status = ST_CORRUPT;
            end
            if (i_q_item.line_end) begin
                n_sp   = '0;
                n_skip = 1'b0;
            end
        end
    end

    // Prefetch the entry under the next top so a pop can follow every cycle that the engine steps
    assign raddr = (n_sp >= SP_W'(2)) ? STK_AW'(n_sp - SP_W'(2)) : '0;
    assign n_fwd = we & (waddr == raddr);

    bmc_ram #(
        .WIDTH (KIND_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_top),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_skip      <= 1'b0;
            r_score     <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp    <= n_sp;
            r_skip  <= n_skip;
            r_score <= n_score;
            r_fwd   <= n_fwd;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_fwd_data <= r_top;
        if (step) begin
            r_out_status <= n_status;
            r_out_score  <= n_score;
            r_out_sp     <= n_sp;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_total_score = r_out_score;
    assign o_stack_depth = r_out_sp;

endmodule

### rtl/core/bracket_match_checker.sv
`timescale 1ns / 1ps
// Top level of the bracket match checker: front end, stack engine, weight registers.
// Depends on bmc_pkg, bmc_cfg, bmc_front, bmc_back, bmc_ram.
//
//   channel   | handshake          | payload
//   ----------+--------------------+----------------------------------------------
//   input     | i_valid / o_ready  | i_symbol[7:0], i_line_end
//   result    | o_valid / i_ready  | o_status[2:0], o_total_score[31:0],
//             |                    | o_stack_depth[6:0]
//   config    | psel/penable/pready| paddr[3:0], pwdata, prdata (weights at 0,4,8,12)
//
// One symbol per cycle sustained while results are taken; a symbol passes through the
// queue, and its result is registered in the result register until it transfers.
// The stack top sits in a register and the entry under it is prefetched from the
// stack RAM every cycle (with a write-to-read bypass), so pushes and pops chain freely.
// Reset empties the stack pointer, skip flag, score and queue; the stack RAM is not cleared.
// A two-entry queue separates intake from the stack engine; a stalled result holds
// its register while the queue keeps taking symbols until full.
module bracket_match_checker
    import bmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic                i_line_end,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SCORE_W-1:0]  o_total_score,
    output logic [DEPTH_W-1:0]  o_stack_depth,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_weights        weights;
    logic            q_valid;
    t_item           q_item;
    logic            q_pop;
    t_status         status;
    logic [SP_W-1:0] depth;

    bmc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_weights (weights)
    );

    bmc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_symbol   (i_symbol),
        .i_line_end (i_line_end),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    bmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_weights     (weights),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (status),
        .o_total_score (o_total_score),
        .o_stack_depth (depth)
    );

    assign o_status      = status;
    assign o_stack_depth = DEPTH_W'(depth);

endmodule
